FILE: sv/hds_pkg.sv
package hds_pkg;

    // default geometry and arithmetic
    localparam int DEF_MAX_ROWS       = 64;
    localparam int DEF_MAX_COLS       = 64;
    localparam int DEF_COEF_FRAC_BITS = 14;

    // fixed field widths
    localparam int VAL_W     = 32;
    localparam int COEF_W    = 16;
    localparam int DIM_W     = 7;
    localparam int IDX_IN_W  = 6;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y    = 2'd3;

    localparam logic [DIM_W-1:0]  RST_GRID_ROWS = 7'd64;
    localparam logic [DIM_W-1:0]  RST_GRID_COLS = 7'd64;
    localparam logic [COEF_W-1:0] RST_COEF_X    = 16'd4096;
    localparam logic [COEF_W-1:0] RST_COEF_Y    = 16'd4096;

    // stencil read phases, three per cell
    localparam logic [1:0] PH_CENTRE = 2'd0;  // centre and up
    localparam logic [1:0] PH_VERT   = 2'd1;  // down and left
    localparam logic [1:0] PH_HORZ   = 2'd2;  // right

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic       load_we;
        logic       rd_issue;
        logic       step_issue;
        logic [1:0] phase;
        logic       capture;
        logic       swap;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic cur_sel;
    } t_dp_stat;

endpackage

FILE: sv/hds_ram.sv
module hds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_qa;
    logic [WIDTH-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_qa <= r_mem[i_raddr_a];
            r_qb <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_qa;
    assign o_rdata_b = r_qb;

endmodule

FILE: sv/hds_ctrl.sv
module hds_ctrl #(
    parameter int MAX_ROWS = hds_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = hds_pkg::DEF_MAX_COLS,
    localparam int RW = $clog2(MAX_ROWS),
    localparam int CW = $clog2(MAX_COLS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [hds_pkg::CMD_W-1:0] i_cmd,
    output logic                     o_stall,
    output logic                     o_valid,
    input  logic                     i_stall,
    input  logic [RW-1:0]            i_last_row,
    input  logic [CW-1:0]            i_last_col,
    input  hds_pkg::t_dp_stat        i_stat,
    output hds_pkg::t_dp_cmd         o_dp_cmd,
    output logic [RW-1:0]            o_row,
    output logic [CW-1:0]            o_col
);
    import hds_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STEP   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_RDWAIT = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [1:0]    r_phase, n_phase;
    logic          r_out_vld, n_out_vld;
    logic          accept;
    logic          slot_free;

    assign o_stall   = (r_state != ST_IDLE);
    assign accept    = i_valid && (r_state == ST_IDLE);
    assign slot_free = !r_out_vld || !i_stall;
    assign o_valid   = r_out_vld;
    assign o_row     = r_row;
    assign o_col     = r_col;

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_phase   = r_phase;
        n_out_vld = r_out_vld && i_stall;
        o_dp_cmd  = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_LOAD: begin
                            o_dp_cmd.load_we = 1'b1;
                        end
                        CMD_STEP: begin
                            n_state = ST_STEP;
                            n_row   = '0;
                            n_col   = '0;
                            n_phase = PH_CENTRE;
                        end
                        CMD_READ: begin
                            o_dp_cmd.rd_issue = 1'b1;
                            n_state           = ST_RDWAIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STEP: begin
                o_dp_cmd.step_issue = 1'b1;
                o_dp_cmd.phase      = r_phase;
                if (r_phase == PH_HORZ) begin
                    n_phase = PH_CENTRE;
                    if (r_col == i_last_col) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                        if (r_row == i_last_row) begin
                            n_state = ST_DRAIN;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end else begin
                    n_phase = (r_phase == PH_CENTRE) ? PH_VERT : PH_HORZ;
                end
            end
            ST_DRAIN: begin
                // swap buffers only once the last write has gone in
                if (!i_stat.pipe_busy) begin
                    o_dp_cmd.swap = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_RDWAIT: begin
                if (slot_free) begin
                    o_dp_cmd.capture = 1'b1;
                    n_out_vld        = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_phase   <= PH_CENTRE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_phase   <= n_phase;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

FILE: sv/hds_dpath.sv
module hds_dpath #(
    parameter int MAX_ROWS       = hds_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS       = hds_pkg::DEF_MAX_COLS,
    parameter int COEF_FRAC_BITS = hds_pkg::DEF_COEF_FRAC_BITS,
    localparam int RW = $clog2(MAX_ROWS),
    localparam int CW = $clog2(MAX_COLS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hds_pkg::COEF_W-1:0]        i_cfg_data,
    input  logic [hds_pkg::IDX_IN_W-1:0]      i_row,
    input  logic [hds_pkg::IDX_IN_W-1:0]      i_col,
    input  logic signed [hds_pkg::VAL_W-1:0]  i_cell_value,
    input  logic                              i_is_fixed,
    input  hds_pkg::t_dp_cmd                  i_dp_cmd,
    input  logic [RW-1:0]                     i_sw_row,
    input  logic [CW-1:0]                     i_sw_col,
    output logic [RW-1:0]                     o_last_row,
    output logic [CW-1:0]                     o_last_col,
    output hds_pkg::t_dp_stat                 o_stat,
    output logic signed [hds_pkg::VAL_W-1:0]  o_read_value,
    output logic                              o_read_fixed,
    output logic                              o_saturated
);
    import hds_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RDW   = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
    localparam int CDW   = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
    localparam int RXW   = RW + IDX_IN_W;
    localparam int CXW   = CW + IDX_IN_W;
    localparam int DIF_W = VAL_W + 2;
    localparam int PRD_W = DIF_W + COEF_W + 1;
    localparam int SUM_W = PRD_W + 1;
    localparam int NV_W  = SUM_W + 1;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // configuration
    logic [DIM_W-1:0]  r_grid_rows;
    logic [DIM_W-1:0]  r_grid_cols;
    logic [COEF_W-1:0] r_coef_x;
    logic [COEF_W-1:0] r_coef_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= RST_GRID_ROWS;
            r_grid_cols <= RST_GRID_COLS;
            r_coef_x    <= RST_COEF_X;
            r_coef_y    <= RST_COEF_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[DIM_W-1:0];
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data[DIM_W-1:0];
                CFG_COEF_X:    r_coef_x    <= i_cfg_data;
                CFG_COEF_Y:    r_coef_y    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // grid size clamped to the supported range
    logic [RDW-1:0] rows_ext, rows_last;
    logic [CDW-1:0] cols_ext, cols_last;

    always_comb begin
        rows_ext = RDW'(r_grid_rows);
        cols_ext = CDW'(r_grid_cols);
        if (rows_ext < RDW'(2)) begin
            rows_last = RDW'(1);
        end else if (rows_ext > RDW'(MAX_ROWS)) begin
            rows_last = RDW'(MAX_ROWS - 1);
        end else begin
            rows_last = rows_ext - 1'b1;
        end
        if (cols_ext < CDW'(2)) begin
            cols_last = CDW'(1);
        end else if (cols_ext > CDW'(MAX_COLS)) begin
            cols_last = CDW'(MAX_COLS - 1);
        end else begin
            cols_last = cols_ext - 1'b1;
        end
    end

    assign o_last_row = rows_last[RW-1:0];
    assign o_last_col = cols_last[CW-1:0];

    // host side address
    logic [RXW-1:0] in_row_x;
    logic [CXW-1:0] in_col_x;
    logic           in_inside;
    logic [AW-1:0]  in_addr;

    assign in_row_x  = RXW'(i_row);
    assign in_col_x  = CXW'(i_col);
    assign in_inside = (in_row_x < RXW'(MAX_ROWS)) && (in_col_x < CXW'(MAX_COLS));
    assign in_addr   = cell_addr(in_row_x[RW-1:0], in_col_x[CW-1:0]);

    // periodic neighbours of the swept cell
    logic [RW-1:0] row_up, row_dn;
    logic [CW-1:0] col_lt, col_rt;
    logic [AW-1:0] centre_addr;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic          rd_en;

    assign row_up      = (i_sw_row == '0) ? o_last_row : i_sw_row - 1'b1;
    assign row_dn      = (i_sw_row == o_last_row) ? '0 : i_sw_row + 1'b1;
    assign col_lt      = (i_sw_col == '0) ? o_last_col : i_sw_col - 1'b1;
    assign col_rt      = (i_sw_col == o_last_col) ? '0 : i_sw_col + 1'b1;
    assign centre_addr = cell_addr(i_sw_row, i_sw_col);
    assign rd_en       = i_dp_cmd.step_issue || i_dp_cmd.rd_issue;

    always_comb begin
        rd_addr_a = in_addr;
        rd_addr_b = in_addr;
        if (i_dp_cmd.step_issue) begin
            case (i_dp_cmd.phase)
                PH_CENTRE: begin
                    rd_addr_a = centre_addr;
                    rd_addr_b = cell_addr(row_up, i_sw_col);
                end
                PH_VERT: begin
                    rd_addr_a = cell_addr(row_dn, i_sw_col);
                    rd_addr_b = cell_addr(i_sw_row, col_lt);
                end
                PH_HORZ: begin
                    rd_addr_a = cell_addr(i_sw_row, col_rt);
                    rd_addr_b = centre_addr;
                end
                default: begin
                    rd_addr_a = centre_addr;
                    rd_addr_b = centre_addr;
                end
            endcase
        end
    end

    // memories and write port
    logic                    r_sel;
    logic                    r_w_vld;
    logic [AW-1:0]           r_w_addr;
    logic signed [VAL_W-1:0] r_w_data;
    logic                    load_go;
    logic                    we_even, we_odd;
    logic [AW-1:0]           waddr;
    logic [VAL_W-1:0]        wdata;
    logic [VAL_W-1:0]        even_qa, even_qb, odd_qa, odd_qb;
    logic [0:0]              mask_qa;
    logic signed [VAL_W-1:0] src_qa, src_qb;

    assign load_go = i_dp_cmd.load_we && in_inside;
    // the buffer that is not current takes the step results
    assign we_even = load_go || (r_w_vld && r_sel);
    assign we_odd  = load_go || (r_w_vld && !r_sel);
    assign waddr   = load_go ? in_addr : r_w_addr;
    assign wdata   = load_go ? i_cell_value : r_w_data;
    assign src_qa  = r_sel ? odd_qa : even_qa;
    assign src_qb  = r_sel ? odd_qb : even_qb;

    hds_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_buf_even (
        .i_clk     (i_clk),
        .i_we      (we_even),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (rd_en),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (even_qa),
        .o_rdata_b (even_qb)
    );

    hds_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_buf_odd (
        .i_clk     (i_clk),
        .i_we      (we_odd),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (rd_en),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (odd_qa),
        .o_rdata_b (odd_qb)
    );

    hds_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_fixed_mask (
        .i_clk     (i_clk),
        .i_we      (load_go),
        .i_waddr   (in_addr),
        .i_wdata   (i_is_fixed),
        .i_re      (rd_en),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_a),
        .o_rdata_a (mask_qa),
        .o_rdata_b ()
    );

    // stencil pipeline
    logic                    r_ph_vld;
    logic [1:0]              r_ph;
    logic [AW-1:0]           r_ph_addr;
    logic signed [VAL_W-1:0] r_u, r_up, r_dn, r_lt;
    logic                    r_fx;

    logic                    r_s2_vld;
    logic signed [DIF_W-1:0] r_s2_dv, r_s2_dh;
    logic signed [VAL_W-1:0] r_s2_u;
    logic                    r_s2_fx;
    logic [AW-1:0]           r_s2_addr;

    logic                    r_s3_vld;
    logic signed [PRD_W-1:0] r_s3_px, r_s3_py;
    logic signed [VAL_W-1:0] r_s3_u;
    logic                    r_s3_fx;
    logic [AW-1:0]           r_s3_addr;

    logic                    r_s4_vld;
    logic signed [SUM_W-1:0] r_s4_sum;
    logic signed [VAL_W-1:0] r_s4_u;
    logic                    r_s4_fx;
    logic [AW-1:0]           r_s4_addr;

    logic signed [SUM_W-1:0] scaled;
    logic signed [NV_W-1:0]  nv;
    logic                    nv_ovf;
    logic                    r_sat;

    assign scaled = r_s4_sum >>> COEF_FRAC_BITS;
    assign nv     = NV_W'(r_s4_u) + NV_W'(scaled);
    assign nv_ovf = (nv[NV_W-1:VAL_W-1] != '0) && (nv[NV_W-1:VAL_W-1] != '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_w_vld  <= 1'b0;
            r_sel    <= 1'b0;
            r_sat    <= 1'b0;
        end else begin
            r_ph_vld <= i_dp_cmd.step_issue;
            r_s2_vld <= r_ph_vld && (r_ph == PH_HORZ);
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_w_vld  <= r_s4_vld;
            if (i_dp_cmd.swap) begin
                r_sel <= !r_sel;
            end
            if (r_s4_vld && !r_s4_fx && nv_ovf) begin
                r_sat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph      <= i_dp_cmd.phase;
        r_ph_addr <= centre_addr;
        if (r_ph_vld) begin
            case (r_ph)
                PH_CENTRE: begin
                    r_u  <= src_qa;
                    r_up <= src_qb;
                    r_fx <= mask_qa[0];
                end
                PH_VERT: begin
                    r_dn <= src_qa;
                    r_lt <= src_qb;
                end
                default: begin
                end
            endcase
        end

        // right neighbour arrives on port a in the last phase
        r_s2_dv   <= DIF_W'(r_up) + DIF_W'(r_dn) - (DIF_W'(r_u) <<< 1);
        r_s2_dh   <= DIF_W'(r_lt) + DIF_W'(src_qa) - (DIF_W'(r_u) <<< 1);
        r_s2_u    <= r_u;
        r_s2_fx   <= r_fx;
        r_s2_addr <= r_ph_addr;

        r_s3_px   <= $signed({1'b0, r_coef_x}) * r_s2_dv;
        r_s3_py   <= $signed({1'b0, r_coef_y}) * r_s2_dh;
        r_s3_u    <= r_s2_u;
        r_s3_fx   <= r_s2_fx;
        r_s3_addr <= r_s2_addr;

        // round half up before the floor shift
        r_s4_sum  <= SUM_W'(r_s3_px) + SUM_W'(r_s3_py) + HALF;
        r_s4_u    <= r_s3_u;
        r_s4_fx   <= r_s3_fx;
        r_s4_addr <= r_s3_addr;

        r_w_addr  <= r_s4_addr;
        if (r_s4_fx) begin
            r_w_data <= r_s4_u;
        end else if (nv_ovf) begin
            r_w_data <= nv[NV_W-1] ? VAL_MIN : VAL_MAX;
        end else begin
            r_w_data <= nv[VAL_W-1:0];
        end
    end

    // read result register
    logic                    r_rd_in;
    logic signed [VAL_W-1:0] r_rd_value;
    logic                    r_rd_fixed;
    logic                    r_rd_sat;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rd_issue) begin
            r_rd_in <= in_inside;
        end
        if (i_dp_cmd.capture) begin
            r_rd_value <= r_rd_in ? src_qa : '0;
            r_rd_fixed <= r_rd_in && mask_qa[0];
            r_rd_sat   <= r_sat;
        end
    end

    assign o_read_value     = r_rd_value;
    assign o_read_fixed     = r_rd_fixed;
    assign o_saturated      = r_rd_sat;
    assign o_stat.pipe_busy = r_ph_vld || r_s2_vld || r_s3_vld || r_s4_vld || r_w_vld;
    assign o_stat.cur_sel   = r_sel;

endmodule

FILE: sv/heat_diffusion_ftcs_step.sv
// channel   dir  handshake          payload
// item      in   i_valid, o_stall   i_cmd i_row i_col i_cell_value i_is_fixed
// result    out  o_valid, i_stall   o_read_value o_read_fixed o_saturated
// config    in   i_cfg_we           i_cfg_idx i_cfg_data
//
// load and the unused command are taken in idle and leave it there; a read goes through the ram read
// register and then into the output register once that is free, and holds the input off until then
// a step reads each cell in three phases and then drains the arithmetic pipeline: the grid
// rams have two read ports and each cell needs five values from them
// reset clears control and the sticky flag and sets the config registers to their defaults;
// grid and mask are undefined until loaded, with no clearing pass
// a result held under i_stall does not block loads or steps; a read waits until the register frees
module heat_diffusion_ftcs_step #(
    parameter int MAX_ROWS       = hds_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS       = hds_pkg::DEF_MAX_COLS,
    parameter int COEF_FRAC_BITS = hds_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [hds_pkg::CMD_W-1:0]         i_cmd,
    input  logic [hds_pkg::IDX_IN_W-1:0]      i_row,
    input  logic [hds_pkg::IDX_IN_W-1:0]      i_col,
    input  logic signed [hds_pkg::VAL_W-1:0]  i_cell_value,
    input  logic                              i_is_fixed,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [hds_pkg::VAL_W-1:0]  o_read_value,
    output logic                              o_read_fixed,
    output logic                              o_saturated,
    input  logic                              i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hds_pkg::COEF_W-1:0]        i_cfg_data
);
    import hds_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [RW-1:0] last_row, sw_row;
    logic [CW-1:0] last_col, sw_col;

    hds_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cmd      (i_cmd),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_last_row (last_row),
        .i_last_col (last_col),
        .i_stat     (dp_stat),
        .o_dp_cmd   (dp_cmd),
        .o_row      (sw_row),
        .o_col      (sw_col)
    );

    hds_dpath #(
        .MAX_ROWS       (MAX_ROWS),
        .MAX_COLS       (MAX_COLS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_value (i_cell_value),
        .i_is_fixed   (i_is_fixed),
        .i_dp_cmd     (dp_cmd),
        .i_sw_row     (sw_row),
        .i_sw_col     (sw_col),
        .o_last_row   (last_row),
        .o_last_col   (last_col),
        .o_stat       (dp_stat),
        .o_read_value (o_read_value),
        .o_read_fixed (o_read_fixed),
        .o_saturated  (o_saturated)
    );

    a_swap_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.swap |-> !dp_stat.pipe_busy)
        else $error("buffer swap with step writes outstanding");

    a_sel_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.swap |=> (dp_stat.cur_sel != $past(dp_stat.cur_sel)))
        else $error("buffer select did not change on swap");

    a_sel_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !dp_cmd.swap |=> $stable(dp_stat.cur_sel))
        else $error("buffer select changed without swap");

    a_ready_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !dp_stat.pipe_busy)
        else $error("new transfer possible while the step pipeline is busy");

    a_capture_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.capture |-> (!o_valid || !i_stall))
        else $error("read result overwrote a held result");

endmodule
